@@ rtl/core/pointing_row_search_assert.svh @@
// ----------------------------------------------------------------------------
// pointing_row_search_assert.svh
// assertion macros shared by the row search rtl
// ----------------------------------------------------------------------------
`ifndef POINTING_ROW_SEARCH_ASSERT_SVH
`define POINTING_ROW_SEARCH_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PRS_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("row search assertion failed");

// next-cycle implication, disabled in reset
`define PRS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("row search assertion failed");

`endif

@@ rtl/core/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// shared constants and types for the pointing row search block
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  // default sizing
  localparam int DEPTH_DEFAULT        = 1024;
  localparam int ANTENNA_BITS_DEFAULT = 8;
  localparam int TIME_BITS_DEFAULT    = 48;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // result flags handed from the search engine to the output stage
  typedef struct packed {
    logic table_full;
    logic found;
  } prs_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/prs_row_mem.sv @@
// ----------------------------------------------------------------------------
// prs_row_mem
// row store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module prs_row_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 104
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/prs_search.sv @@
// ----------------------------------------------------------------------------
// prs_search
// command sequencer: appends rows, clears the table and walks the row
// store for a query, with a neighbour search for rows of zero interval
// ----------------------------------------------------------------------------
`default_nettype none

`include "pointing_row_search_assert.svh"

module prs_search
  import prs_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEFAULT,
  parameter int ANTENNA_BITS = ANTENNA_BITS_DEFAULT,
  parameter int TIME_BITS    = TIME_BITS_DEFAULT
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // command beat
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic [1:0]                                in_op,
  input  wire logic [ANTENNA_BITS-1:0]                   in_antenna,
  input  wire logic [TIME_BITS-1:0]                      in_time,
  input  wire logic [TIME_BITS-1:0]                      in_span,
  input  wire logic [$clog2(DEPTH+1)-1:0]                in_start,
  // row store
  output logic                                           wr_en,
  output logic [$clog2(DEPTH)-1:0]                       wr_addr,
  output logic [ANTENNA_BITS+2*TIME_BITS-1:0]            wr_data,
  output logic                                           rd_en,
  output logic [$clog2(DEPTH)-1:0]                       rd_addr,
  input  wire logic [ANTENNA_BITS+2*TIME_BITS-1:0]       rd_data,
  // result
  output logic                                           res_valid,
  input  wire logic                                      res_ready,
  output prs_flags_t                                     res_flags,
  output logic [$clog2(DEPTH)-1:0]                       res_index
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_EV  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_SUB_RD   = 4'd4;
  localparam logic [3:0] S_SUB_EV   = 4'd5;
  localparam logic [3:0] S_SUB_CMP  = 4'd6;
  localparam logic [3:0] S_RESP     = 4'd7;

  logic [3:0]              state;
  logic [CW-1:0]           count;
  logic [ANTENNA_BITS-1:0] ant;
  logic [TIME_BITS-1:0]    qtime;
  logic [AW-1:0]           row_i;
  logic [CW-1:0]           left;
  logic [AW-1:0]           sub_j;
  logic                    sub_down;
  logic [TIME_BITS-1:0]    row_t;
  logic [TIME_BITS-1:0]    row_s;
  logic [TIME_BITS-1:0]    dq;
  logic [TIME_BITS-1:0]    od;

  logic [ANTENNA_BITS-1:0] rd_ant;
  logic [TIME_BITS-1:0]    rd_time;
  logic [TIME_BITS-1:0]    rd_span;
  logic [CW-1:0]           clamp;
  logic                    table_at_limit;
  logic                    row_is_last;
  logic [AW-1:0]           row_next;
  logic                    up_has_more;
  logic                    sub_hit;
  logic                    span_fits;
  logic                    other_fits;

  function automatic logic [TIME_BITS-1:0] abs_diff(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // row layout: time low, span, antenna high
  assign rd_time = rd_data[TIME_BITS-1:0];
  assign rd_span = rd_data[2*TIME_BITS-1:TIME_BITS];
  assign rd_ant  = rd_data[ANTENNA_BITS+2*TIME_BITS-1:2*TIME_BITS];

  // scan bookkeeping
  assign clamp          = (in_start > count) ? count : in_start;
  assign table_at_limit = (count == CW'(DEPTH));
  assign row_is_last    = ((CW'(row_i) + CW'(1)) == count);
  assign row_next       = row_is_last ? '0 : row_i + AW'(1);
  assign up_has_more    = ((CW'(sub_j) + CW'(1)) < count);
  assign sub_hit        = (rd_ant == ant) && (rd_time != row_t);

  // doubled distance against interval or neighbour gap
  assign span_fits  = ({dq, 1'b0} <= {1'b0, row_s});
  assign other_fits = ({dq, 1'b0} <= {1'b0, od});

  // store ports: write on an accepted append while the table is not full, read in the read states
  assign in_ready  = (state == S_IDLE);
  assign wr_en     = in_valid && (state == S_IDLE) && (in_op == OP_APPEND) && !table_at_limit;
  assign wr_addr   = count[AW-1:0];
  assign wr_data   = {in_antenna, in_span, in_time};
  assign rd_en     = (state == S_SCAN_RD) || (state == S_SUB_RD);
  assign rd_addr   = (state == S_SUB_RD) ? sub_j : row_i;
  assign res_valid = (state == S_RESP);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ant       <= in_antenna;
            qtime     <= in_time;
            res_flags <= '0;
            res_index <= '0;
            state     <= S_RESP;
            case (in_op)
              OP_APPEND: begin
                if (table_at_limit) begin
                  res_flags.table_full <= 1'b1;
                end else begin
                  res_index <= count[AW-1:0];
                  count     <= count + CW'(1);
                end
              end
              OP_CLEAR: begin
                count <= '0;
              end
              OP_QUERY: begin
                if (count != '0) begin
                  row_i <= (clamp == count) ? '0 : clamp[AW-1:0];
                  left  <= count;
                  state <= S_SCAN_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (rd_ant == ant) begin
            row_t <= rd_time;
            row_s <= rd_span;
            dq    <= abs_diff(rd_time, qtime);
            state <= S_SCAN_CMP;
          end else if (left == CW'(1)) begin
            state <= S_RESP;
          end else begin
            left  <= left - CW'(1);
            row_i <= row_next;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_CMP: begin
          if (row_s == '0) begin
            // zero interval: look for a neighbour of the same antenna
            if ((CW'(row_i) + CW'(1)) < count) begin
              sub_j    <= row_i + AW'(1);
              sub_down <= 1'b0;
              state    <= S_SUB_RD;
            end else if (row_i != '0) begin
              sub_j    <= row_i - AW'(1);
              sub_down <= 1'b1;
              state    <= S_SUB_RD;
            end else begin
              res_flags.found <= 1'b1;
              res_index       <= row_i;
              state           <= S_RESP;
            end
          end else if (row_s[TIME_BITS-1] || span_fits) begin
            res_flags.found <= 1'b1;
            res_index       <= row_i;
            state           <= S_RESP;
          end else if (left == CW'(1)) begin
            state <= S_RESP;
          end else begin
            left  <= left - CW'(1);
            row_i <= row_next;
            state <= S_SCAN_RD;
          end
        end
        S_SUB_RD: begin
          state <= S_SUB_EV;
        end
        S_SUB_EV: begin
          if (sub_hit) begin
            od    <= abs_diff(rd_time, row_t);
            state <= S_SUB_CMP;
          end else if (!sub_down && up_has_more) begin
            sub_j <= sub_j + AW'(1);
            state <= S_SUB_RD;
          end else if (!sub_down && (row_i != '0)) begin
            sub_j    <= row_i - AW'(1);
            sub_down <= 1'b1;
            state    <= S_SUB_RD;
          end else if (sub_down && (sub_j != '0)) begin
            sub_j <= sub_j - AW'(1);
            state <= S_SUB_RD;
          end else begin
            // no neighbour at all: the row matches
            res_flags.found <= 1'b1;
            res_index       <= row_i;
            state           <= S_RESP;
          end
        end
        S_SUB_CMP: begin
          if (other_fits) begin
            res_flags.found <= 1'b1;
            res_index       <= row_i;
            state           <= S_RESP;
          end else if (left == CW'(1)) begin
            state <= S_RESP;
          end else begin
            left  <= left - CW'(1);
            row_i <= row_next;
            state <= S_SCAN_RD;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `PRS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `PRS_ASSERT_IMP(a_no_rw_overlap, clk, rst, wr_en, !rd_en)
  `PRS_ASSERT_IMP(a_found_in_table, clk, rst, res_valid && res_flags.found, CW'(res_index) < count)
  `PRS_ASSERT_IMP(a_flags_exclusive, clk, rst, res_valid, !(res_flags.found && res_flags.table_full))
  `PRS_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

@@ rtl/core/pointing_row_search.sv @@
// append, clear and unused codes go from the input beat to the result state and then the output register
// query: each row is read and its antenna checked; a row of the queried antenna also gets a compare step,
// and a zero-interval row adds a read per row visited in the neighbour search and a compare per partner
// the single read port of the row store sets the query time; one command at a time
// reset clears the row count, the sequencer and the output beat; rows are not cleared
// ----------------------------------------------------------------------------
// pointing_row_search
// row table with antenna/time lookup from a guessed starting row
// ----------------------------------------------------------------------------
`default_nettype none

module pointing_row_search
  import prs_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEFAULT,
  parameter int ANTENNA_BITS = ANTENNA_BITS_DEFAULT,
  parameter int TIME_BITS    = TIME_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  // command stream
  input  wire logic s_tvalid,
  output logic      s_tready,
  // antenna, sample_time, span, start_row
  input  wire logic [((ANTENNA_BITS+2*TIME_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] s_tdata,
  // operation
  input  wire logic [1:0] s_tuser,
  // result stream
  output logic      m_tvalid,
  input  wire logic m_tready,
  // row_index
  output logic [(($clog2(DEPTH)+7)/8)*8-1:0] m_tdata,
  // found, table_full
  output logic [1:0] m_tuser
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH+1);
  localparam int RW    = ANTENNA_BITS + 2*TIME_BITS;
  localparam int OUT_W = ((AW+7)/8)*8;

  logic                    cmd_ready;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [RW-1:0]           wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [RW-1:0]           rd_data;
  logic                    res_valid;
  logic                    res_ready;
  prs_flags_t              res_flags;
  logic [AW-1:0]           res_index;
  prs_flags_t              out_flags;
  logic [AW-1:0]           out_index;

  assign s_tready = cmd_ready;

  prs_search #(
    .DEPTH        (DEPTH),
    .ANTENNA_BITS (ANTENNA_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (cmd_ready),
    .in_op      (s_tuser),
    .in_antenna (s_tdata[ANTENNA_BITS-1:0]),
    .in_time    (s_tdata[ANTENNA_BITS+TIME_BITS-1:ANTENNA_BITS]),
    .in_span    (s_tdata[ANTENNA_BITS+2*TIME_BITS-1:ANTENNA_BITS+TIME_BITS]),
    .in_start   (s_tdata[ANTENNA_BITS+2*TIME_BITS+CW-1:ANTENNA_BITS+2*TIME_BITS]),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_flags  (res_flags),
    .res_index  (res_index)
  );

  prs_row_mem #(
    .DEPTH (DEPTH),
    .WIDTH (RW)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: takes a result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_flags <= res_flags;
      out_index <= res_index;
    end
  end

  // output beat packing
  assign m_tdata = OUT_W'(out_index);
  assign m_tuser = {out_flags.table_full, out_flags.found};

endmodule

`default_nettype wire
